[src/irlp_pkg.sv]
// Shared constants and types for the index range list parser.
package irlp_pkg;

  localparam int          VALUE_WIDTH = 32;
  localparam logic [31:0] MAX_RANGE   = 32'd1048576;
  localparam int          FIFO_DEPTH  = 4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_MALFORMED = 3'd2;
  localparam logic [2:0] ST_OVERFLOW  = 3'd3;
  localparam logic [2:0] ST_RANGE     = 3'd4;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_DASH  = 8'h2d;

  // classification of one finished element, queued between front and back
  typedef struct packed {
    logic empty;
    logic bad;
    logic ovf;
    logic done;
    logic extra;
  } irlp_flags_t;

endpackage

[src/irlp_in_if.sv]
// Input channel: one text byte per word.
interface irlp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_list;

  modport source (output valid, text_byte, end_of_list, input ready);
  modport sink (input valid, text_byte, end_of_list, output ready);
endinterface

[src/irlp_out_if.sv]
// Result channel: one parsed element per word.
interface irlp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] first_index;
  logic [31:0] last_index;
  logic        list_done;

  modport source (output valid, status, first_index, last_index, list_done, input ready);
  modport sink (input valid, status, first_index, last_index, list_done, output ready);
endinterface

[src/irlp_front.sv]
// Front end: per-byte element scanner that emits one classified record per element.
module irlp_front #(
  parameter int VALUE_WIDTH = irlp_pkg::VALUE_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     take,
  input  logic [7:0]               text_byte,
  input  logic                     end_of_list,
  output logic                     push,
  output irlp_pkg::irlp_flags_t    rec_flags,
  output logic [VALUE_WIDTH-1:0]   rec_lo,
  output logic [VALUE_WIDTH-1:0]   rec_hi
);

  localparam logic [1:0] PH_LEAD   = 2'd0;
  localparam logic [1:0] PH_FIRST  = 2'd1;
  localparam logic [1:0] PH_SECOND = 2'd2;

  logic [1:0]             phase, phase_next;
  logic [VALUE_WIDTH-1:0] first_num, first_num_next;
  logic [VALUE_WIDTH-1:0] second_num, second_num_next;
  logic                   first_dig, first_dig_next;
  logic                   second_dig, second_dig_next;
  logic                   dash, dash_next;
  logic                   malformed, malformed_next;
  logic                   overflow, overflow_next;
  logic                   gap, gap_next;

  logic                   is_comma, is_ws, is_dash, is_digit;
  logic [VALUE_WIDTH-1:0] acc_in;
  logic [VALUE_WIDTH+3:0] acc_prod;
  logic                   acc_ovf;

  assign is_comma = text_byte == irlp_pkg::CH_COMMA;
  assign is_ws    = text_byte <= irlp_pkg::CH_SPACE;
  assign is_dash  = text_byte == irlp_pkg::CH_DASH;
  assign is_digit = text_byte >= irlp_pkg::CH_ZERO && text_byte <= irlp_pkg::CH_NINE;

  // num*10 + digit; anything above the value width is overflow
  assign acc_in   = (phase == PH_SECOND) ? second_num : first_num;
  assign acc_prod = {1'b0, acc_in, 3'b000} + {3'b000, acc_in, 1'b0}
                  + {{VALUE_WIDTH{1'b0}}, text_byte[3:0]};
  assign acc_ovf  = |acc_prod[VALUE_WIDTH+3:VALUE_WIDTH];

  always_comb begin
    phase_next      = phase;
    first_num_next  = first_num;
    second_num_next = second_num;
    first_dig_next  = first_dig;
    second_dig_next = second_dig;
    dash_next       = dash;
    malformed_next  = malformed;
    overflow_next   = overflow;
    gap_next        = gap;
    if (is_ws) begin
      if (phase != PH_LEAD) begin
        gap_next = 1'b1;
      end
    end else begin
      if (gap) begin
        malformed_next = 1'b1;
      end
      if (is_dash) begin
        if (dash) begin
          malformed_next = 1'b1;
        end
        dash_next  = 1'b1;
        phase_next = PH_SECOND;
      end else if (is_digit) begin
        if (phase == PH_SECOND) begin
          second_dig_next = 1'b1;
        end else begin
          phase_next     = PH_FIRST;
          first_dig_next = 1'b1;
        end
        if (!overflow) begin
          if (acc_ovf) begin
            overflow_next = 1'b1;
          end else if (phase == PH_SECOND) begin
            second_num_next = acc_prod[VALUE_WIDTH-1:0];
          end else begin
            first_num_next = acc_prod[VALUE_WIDTH-1:0];
          end
        end
      end else begin
        malformed_next = 1'b1;
        if (phase == PH_LEAD) begin
          phase_next = PH_FIRST;
        end
      end
    end
  end

  // a comma closes the element as it stood; a last byte closes it after the byte
  always_comb begin
    if (is_comma) begin
      rec_flags.empty = phase == PH_LEAD && !dash;
      rec_flags.bad   = malformed || !first_dig || (dash && !second_dig);
      rec_flags.ovf   = overflow;
      rec_lo          = first_num;
      rec_hi          = dash ? second_num : first_num;
    end else begin
      rec_flags.empty = phase_next == PH_LEAD && !dash_next;
      rec_flags.bad   = malformed_next || !first_dig_next || (dash_next && !second_dig_next);
      rec_flags.ovf   = overflow_next;
      rec_lo          = first_num_next;
      rec_hi          = dash_next ? second_num_next : first_num_next;
    end
    rec_flags.done  = end_of_list && !is_comma;
    rec_flags.extra = end_of_list && is_comma;
  end

  assign push = take && (is_comma || end_of_list);

  always_ff @(posedge clk) begin
    if (rst || push) begin
      phase      <= PH_LEAD;
      first_num  <= '0;
      second_num <= '0;
      first_dig  <= 1'b0;
      second_dig <= 1'b0;
      dash       <= 1'b0;
      malformed  <= 1'b0;
      overflow   <= 1'b0;
      gap        <= 1'b0;
    end else if (take) begin
      phase      <= phase_next;
      first_num  <= first_num_next;
      second_num <= second_num_next;
      first_dig  <= first_dig_next;
      second_dig <= second_dig_next;
      dash       <= dash_next;
      malformed  <= malformed_next;
      overflow   <= overflow_next;
      gap        <= gap_next;
    end
  end

endmodule

[src/irlp_fifo.sv]
// Short record queue between the scanner and the result stage.
module irlp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = irlp_pkg::FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             not_empty,
  output logic             full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [AW:0]      count;

  assign rdata     = mem[rd_ptr];
  assign not_empty = count != '0;
  assign full      = count == (AW+1)'(DEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[src/irlp_back.sv]
// Back end: range check, status selection and the registered result word.
module irlp_back #(
  parameter int          VALUE_WIDTH = irlp_pkg::VALUE_WIDTH,
  parameter logic [31:0] MAX_RANGE   = irlp_pkg::MAX_RANGE
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   head_valid,
  input  irlp_pkg::irlp_flags_t  head_flags,
  input  logic [VALUE_WIDTH-1:0] head_lo,
  input  logic [VALUE_WIDTH-1:0] head_hi,
  output logic                   pop,
  irlp_out_if.source             out_ch
);

  localparam int CW = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;

  logic                   load, sub;
  logic [VALUE_WIDTH-1:0] diff;
  logic                   reject;
  logic [2:0]             status_next;

  assign diff   = head_hi - head_lo;
  assign reject = head_hi < head_lo || CW'(diff) >= CW'(MAX_RANGE);

  always_comb begin
    if (head_flags.empty) begin
      status_next = irlp_pkg::ST_EMPTY;
    end else if (head_flags.bad) begin
      status_next = irlp_pkg::ST_MALFORMED;
    end else if (head_flags.ovf) begin
      status_next = irlp_pkg::ST_OVERFLOW;
    end else if (reject) begin
      status_next = irlp_pkg::ST_RANGE;
    end else begin
      status_next = irlp_pkg::ST_OK;
    end
  end

  assign load = !out_ch.valid || out_ch.ready;
  assign pop  = load && head_valid && (sub || !head_flags.extra);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
      sub          <= 1'b0;
    end else if (load) begin
      out_ch.valid <= head_valid;
      if (head_valid) begin
        sub <= !sub && head_flags.extra;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      if (sub) begin
        // trailing comma at end of list: empty final element
        out_ch.status      <= irlp_pkg::ST_EMPTY;
        out_ch.first_index <= '0;
        out_ch.last_index  <= '0;
        out_ch.list_done   <= 1'b1;
      end else begin
        out_ch.status      <= status_next;
        out_ch.first_index <= (status_next == irlp_pkg::ST_OK) ? 32'(head_lo) : '0;
        out_ch.last_index  <= (status_next == irlp_pkg::ST_OK) ? 32'(head_hi) : '0;
        out_ch.list_done   <= head_flags.done;
      end
    end
  end

endmodule

[src/index_range_list_parser_core.sv]
// Index range list parser: top level joining scanner, record queue and result stage.
//
// in_ch carries the list text one byte per word, with end_of_list set on the
// last byte. out_ch carries one word per element: status, first and last
// index and list_done on the final element of the list.
// A byte is taken every cycle while the record queue has room; the scanner
// updates its registered element state with each byte taken (multiply-by-ten accumulate).
// An element closed by a comma or by the last byte is queued as one record;
// the result stage loads the record at the head of the queue into the
// registered result word when the output register is empty or being taken.
// A comma that is also the last byte yields two result words from one record,
// the second an empty element.
// When out_ch is stalled the queue (FIFO_DEPTH records) absorbs elements
// and in_ch.ready drops only once it is full.
// Reset (rst, synchronous) empties the queue and the output register and
// returns the scanner to the start of an element.
module index_range_list_parser_core #(
  parameter int          VALUE_WIDTH = irlp_pkg::VALUE_WIDTH,
  parameter logic [31:0] MAX_RANGE   = irlp_pkg::MAX_RANGE,
  parameter int          FIFO_DEPTH  = irlp_pkg::FIFO_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  irlp_in_if.sink   in_ch,
  irlp_out_if.source out_ch
);

  localparam int FLW = $bits(irlp_pkg::irlp_flags_t);
  localparam int RW  = FLW + 2 * VALUE_WIDTH;

  logic                   take, push, pop, head_valid, full;
  irlp_pkg::irlp_flags_t  rec_flags, head_flags;
  logic [VALUE_WIDTH-1:0] rec_lo, rec_hi, head_lo, head_hi;
  logic [RW-1:0]          head_word;

  assign in_ch.ready = !full;
  assign take        = in_ch.valid && !full;

  irlp_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .text_byte  (in_ch.text_byte),
    .end_of_list(in_ch.end_of_list),
    .push       (push),
    .rec_flags  (rec_flags),
    .rec_lo     (rec_lo),
    .rec_hi     (rec_hi)
  );

  irlp_fifo #(
    .WIDTH(RW),
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wdata    ({rec_flags, rec_lo, rec_hi}),
    .pop      (pop),
    .rdata    (head_word),
    .not_empty(head_valid),
    .full     (full)
  );

  assign head_flags = head_word[RW-1 -: FLW];
  assign head_lo    = head_word[2*VALUE_WIDTH-1 -: VALUE_WIDTH];
  assign head_hi    = head_word[VALUE_WIDTH-1:0];

  irlp_back #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .MAX_RANGE  (MAX_RANGE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head_flags(head_flags),
    .head_lo   (head_lo),
    .head_hi   (head_hi),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule
